@@ rtl/core/iwm_pkg.sv @@
// Package for the iris wipe mask unit: screen and cell sizes, codes and the
// queue entry type shared by the front, the queue and the back.
// No dependencies.
`timescale 1ns / 1ps

package iwm_pkg;

    localparam int SCREEN_WIDTH  = 1024;
    localparam int SCREEN_HEIGHT = 1024;
    localparam int CELL_WIDTH    = 4;
    localparam int CELL_HEIGHT   = 4;

    localparam int COORD_W = 10;
    localparam int SQ_W    = 2 * COORD_W;
    localparam int QDEPTH  = 4;

    typedef enum logic [1:0] {
        KIND_START = 2'd0,
        KIND_TICK  = 2'd1,
        KIND_QUERY = 2'd2,
        KIND_NOP   = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        MODE_NONE  = 2'd0,
        MODE_OPEN  = 2'd1,
        MODE_CLOSE = 2'd2,
        MODE_BAD   = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        REG_CENTER_X   = 2'd0,
        REG_CENTER_Y   = 2'd1,
        REG_WIPE_STEPS = 2'd2,
        REG_UNUSED     = 2'd3
    } reg_idx_t;

    localparam logic [COORD_W-1:0] WIPE_STEPS_RESET = COORD_W'(32);

    // One classified beat on its way from the front to the back.
    typedef struct packed {
        logic               is_query;
        logic               mask_shown;
        logic               wipe_active;
        logic [COORD_W-1:0] radius;
        logic [COORD_W-1:0] pixel_x;
        logic [COORD_W-1:0] pixel_y;
    } iwm_entry_t;

endpackage

@@ rtl/core/iwm_if.sv @@
// Valid/ready channel interfaces for input items and result items.
// Depends on iwm_pkg.
`timescale 1ns / 1ps

interface iwm_in_if
    import iwm_pkg::*;
();
    logic               valid;
    logic               ready;
    logic [1:0]         kind;
    logic [1:0]         start_mode;
    logic [COORD_W-1:0] pixel_x;
    logic [COORD_W-1:0] pixel_y;

    modport source (output valid, kind, start_mode, pixel_x, pixel_y, input ready);
    modport sink   (input valid, kind, start_mode, pixel_x, pixel_y, output ready);
endinterface

interface iwm_out_if
    import iwm_pkg::*;
();
    logic               valid;
    logic               ready;
    logic               mask_shown;
    logic               pixel_black;
    logic               wipe_active;
    logic [COORD_W-1:0] radius;

    modport source (output valid, mask_shown, pixel_black, wipe_active, radius, input ready);
    modport sink   (input valid, mask_shown, pixel_black, wipe_active, radius, output ready);
endinterface

@@ rtl/core/iwm_front.sv @@
// Front of the iris wipe mask: accepts beats, updates the wipe state and
// pushes a classified entry into the queue. Depends on iwm_pkg.
`timescale 1ns / 1ps

module iwm_front
    import iwm_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               item_valid,
    output logic               item_ready,
    input  logic [1:0]         item_kind,
    input  logic [1:0]         item_start_mode,
    input  logic [COORD_W-1:0] item_pixel_x,
    input  logic [COORD_W-1:0] item_pixel_y,
    input  logic [COORD_W-1:0] wipe_steps,
    output logic               push_valid,
    input  logic               push_ready,
    output iwm_entry_t         push_data
);

    mode_t              mode_reg, mode_next;
    logic               running_reg, running_next;
    logic [COORD_W-1:0] step_reg, step_next;
    logic [COORD_W-1:0] radius_reg, radius_next;
    logic               accept;

    assign item_ready = push_ready;
    assign push_valid = item_valid;
    assign accept     = item_valid && push_ready;

    always_comb
    begin
        mode_next    = mode_reg;
        running_next = running_reg;
        step_next    = step_reg;
        radius_next  = radius_reg;
        if (accept)
        begin
            case (kind_t'(item_kind))
                KIND_START:
                begin
                    if (!running_reg)
                    begin
                        mode_next   = (mode_t'(item_start_mode) == MODE_BAD) ?
                                      MODE_NONE : mode_t'(item_start_mode);
                        step_next   = '0;
                        radius_next = '0;
                    end
                    running_next = 1'b1;
                end
                KIND_TICK:
                begin
                    if (mode_reg != MODE_NONE)
                    begin
                        if (!running_reg)
                        begin
                            radius_next = '0;
                        end
                        else
                        begin
                            if (step_reg == wipe_steps)
                            begin
                                running_next = 1'b0;
                                if (mode_reg == MODE_OPEN)
                                begin
                                    mode_next = MODE_NONE;
                                end
                            end
                            else
                            begin
                                step_next = step_reg + COORD_W'(1);
                            end
                            if (mode_next == MODE_CLOSE)
                            begin
                                radius_next = (step_next >= wipe_steps) ?
                                              '0 : wipe_steps - step_next;
                            end
                            else
                            begin
                                radius_next = step_next;
                            end
                        end
                    end
                end
                default:
                begin
                    // queries and unused codes leave the state alone
                end
            endcase
        end
    end

    always_comb
    begin
        push_data.is_query    = (kind_t'(item_kind) == KIND_QUERY);
        push_data.mask_shown  = (mode_next != MODE_NONE);
        push_data.wipe_active = running_next;
        push_data.radius      = radius_next;
        push_data.pixel_x     = item_pixel_x;
        push_data.pixel_y     = item_pixel_y;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg    <= MODE_NONE;
            running_reg <= 1'b0;
            step_reg    <= '0;
            radius_reg  <= '0;
        end
        else
        begin
            mode_reg    <= mode_next;
            running_reg <= running_next;
            step_reg    <= step_next;
            radius_reg  <= radius_next;
        end
    end

endmodule

@@ rtl/core/iwm_queue.sv @@
// Short FIFO between the front and the back of the iris wipe mask.
// Depends on iwm_pkg.
`timescale 1ns / 1ps

module iwm_queue
    import iwm_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push_valid,
    output logic       push_ready,
    input  iwm_entry_t push_data,
    output logic       pop_valid,
    input  logic       pop_ready,
    output iwm_entry_t pop_data
);

    localparam int PTR_W = $clog2(QDEPTH);
    localparam int CNT_W = $clog2(QDEPTH + 1);

    iwm_entry_t       slot_reg [QDEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             push, pop;

    assign push_ready = (count_reg != CNT_W'(QDEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = slot_reg[rd_ptr_reg];
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + PTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + PTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

`ifndef NO_ASSERTIONS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(QDEPTH))
        else $error("queue count beyond depth");

    a_count_up: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop) |=> count_reg == $past(count_reg) + CNT_W'(1))
        else $error("queue count did not rise on push");

    a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg != CNT_W'(QDEPTH)) |-> (wr_ptr_reg - rd_ptr_reg) == PTR_W'(count_reg))
        else $error("queue pointers disagree with count");
`endif

endmodule

@@ rtl/core/iwm_back.sv @@
// Back of the iris wipe mask: three-stage pixel test (offsets, squares,
// compare) ending in the result register. Depends on iwm_pkg.
`timescale 1ns / 1ps

module iwm_back
    import iwm_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic [COORD_W-1:0] center_x,
    input  logic [COORD_W-1:0] center_y,
    input  logic               pop_valid,
    output logic               pop_ready,
    input  iwm_entry_t         pop_data,
    output logic               res_valid,
    input  logic               res_ready,
    output logic               res_mask_shown,
    output logic               res_pixel_black,
    output logic               res_wipe_active,
    output logic [COORD_W-1:0] res_radius
);

    logic               adv;
    logic [COORD_W-1:0] dx, dy;
    logic               on_screen;

    logic               s1_valid_reg;
    iwm_entry_t         s1_ent_reg;
    logic               s1_out_reg;
    logic [COORD_W-1:0] s1_tx_reg, s1_ty_reg;

    logic               s2_valid_reg;
    iwm_entry_t         s2_ent_reg;
    logic               s2_out_reg;
    logic [SQ_W-1:0]    s2_sx_reg, s2_sy_reg, s2_r2_reg;
    logic [SQ_W:0]      s2_sum;

    logic               out_valid_reg;
    logic               out_shown_reg, out_black_reg, out_active_reg;
    logic [COORD_W-1:0] out_radius_reg;

    // advance the whole pipe whenever the result register is free or draining
    assign adv       = !out_valid_reg || res_ready;
    assign pop_ready = adv;

    assign dx = (pop_data.pixel_x >= center_x) ? pop_data.pixel_x - center_x :
                                                 center_x - pop_data.pixel_x;
    assign dy = (pop_data.pixel_y >= center_y) ? pop_data.pixel_y - center_y :
                                                 center_y - pop_data.pixel_y;
    assign on_screen = (32'(pop_data.pixel_x) < SCREEN_WIDTH) &&
                       (32'(pop_data.pixel_y) < SCREEN_HEIGHT);

    assign s2_sum = {1'b0, s2_sx_reg} + {1'b0, s2_sy_reg};

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_ent_reg <= pop_data;
            s1_out_reg <= !on_screen || (dx > pop_data.radius) || (dy > pop_data.radius);
            s1_tx_reg  <= COORD_W'((32'(dx) / CELL_WIDTH) * CELL_WIDTH);
            s1_ty_reg  <= COORD_W'((32'(dy) / CELL_HEIGHT) * CELL_HEIGHT);

            s2_ent_reg <= s1_ent_reg;
            s2_out_reg <= s1_out_reg;
            s2_sx_reg  <= SQ_W'(s1_tx_reg) * SQ_W'(s1_tx_reg);
            s2_sy_reg  <= SQ_W'(s1_ty_reg) * SQ_W'(s1_ty_reg);
            s2_r2_reg  <= SQ_W'(s1_ent_reg.radius) * SQ_W'(s1_ent_reg.radius);

            out_shown_reg  <= s2_ent_reg.mask_shown;
            out_active_reg <= s2_ent_reg.wipe_active;
            out_radius_reg <= s2_ent_reg.radius;
            out_black_reg  <= s2_ent_reg.is_query &&
                              (s2_out_reg || !(s2_sum < {1'b0, s2_r2_reg}));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s1_valid_reg  <= pop_valid;
            s2_valid_reg  <= s1_valid_reg;
            out_valid_reg <= s2_valid_reg;
        end
    end

    assign res_valid       = out_valid_reg;
    assign res_mask_shown  = out_shown_reg;
    assign res_pixel_black = out_black_reg;
    assign res_wipe_active = out_active_reg;
    assign res_radius      = out_radius_reg;

endmodule

@@ rtl/core/iris_wipe_mask_unit.sv @@
// Top level of the iris wipe mask unit: configuration registers and the
// front, queue and back. Depends on iwm_pkg, iwm_if, iwm_front, iwm_queue, iwm_back.
`timescale 1ns / 1ps

// The unit takes one beat per clock on item and returns exactly one result
// beat per item, in order, on result. Start and frame-tick beats update the
// wipe state in the front as they are accepted; every beat then travels
// through a 4-entry queue into a 3-stage pixel test (center offsets and
// cell truncation, squares, compare) whose last stage is the result
// register. Throughput is one item per cycle while result is ready. The
// unit holds at most 7 items (4 in the queue, 3 in the pipe); when result
// stalls the pipe freezes and only the queue takes further beats, so
// item.ready drops after at most 4 more items. Write center_x, center_y
// and wipe_steps through the cfg port only while no item is in flight.

module iris_wipe_mask_unit
    import iwm_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    iwm_in_if.sink             item,
    iwm_out_if.source          result,
    input  logic               cfg_write,
    input  logic [1:0]         cfg_index,
    input  logic [COORD_W-1:0] cfg_data
);

    logic [COORD_W-1:0] center_x_reg;
    logic [COORD_W-1:0] center_y_reg;
    logic [COORD_W-1:0] wipe_steps_reg;

    logic       push_valid, push_ready;
    iwm_entry_t push_data;
    logic       pop_valid, pop_ready;
    iwm_entry_t pop_data;

    // Register file: writes beyond the list are dropped.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            center_x_reg   <= '0;
            center_y_reg   <= '0;
            wipe_steps_reg <= WIPE_STEPS_RESET;
        end
        else if (cfg_write)
        begin
            case (reg_idx_t'(cfg_index))
                REG_CENTER_X:   center_x_reg   <= cfg_data;
                REG_CENTER_Y:   center_y_reg   <= cfg_data;
                REG_WIPE_STEPS: wipe_steps_reg <= cfg_data;
                default:
                begin
                    // drop the write
                end
            endcase
        end
    end

    // Front: classify each beat and advance the wipe state.
    iwm_front u_front (
        .clk             (clk),
        .rst_n           (rst_n),
        .item_valid      (item.valid),
        .item_ready      (item.ready),
        .item_kind       (item.kind),
        .item_start_mode (item.start_mode),
        .item_pixel_x    (item.pixel_x),
        .item_pixel_y    (item.pixel_y),
        .wipe_steps      (wipe_steps_reg),
        .push_valid      (push_valid),
        .push_ready      (push_ready),
        .push_data       (push_data)
    );

    // Queue: hold classified beats so front and back stall on their own.
    iwm_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data)
    );

    // Back: test the pixel against the iris and drive the result beat.
    iwm_back u_back (
        .clk             (clk),
        .rst_n           (rst_n),
        .center_x        (center_x_reg),
        .center_y        (center_y_reg),
        .pop_valid       (pop_valid),
        .pop_ready       (pop_ready),
        .pop_data        (pop_data),
        .res_valid       (result.valid),
        .res_ready       (result.ready),
        .res_mask_shown  (result.mask_shown),
        .res_pixel_black (result.pixel_black),
        .res_wipe_active (result.wipe_active),
        .res_radius      (result.radius)
    );

endmodule

@@ tb/sv/iwm_mask_checker.sv @@
`timescale 1ns / 1ps
// Result checker for the iris wipe mask unit: tracks the wipe state from the
// item beats and compares every result beat. Depends on iwm_pkg and iwm_if.

module iwm_mask_checker
    import iwm_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    iwm_in_if                  item,
    iwm_out_if                 result,
    input  logic               cfg_write,
    input  logic [1:0]         cfg_index,
    input  logic [COORD_W-1:0] cfg_data,
    output int                 errors,
    output int                 pending,
    output logic [COORD_W-1:0] wipe_count
);

    typedef struct packed {
        logic               shown;
        logic               black;
        logic               active;
        logic [COORD_W-1:0] radius;
    } mask_status_t;

    mask_status_t       pending_status[$];
    logic [COORD_W-1:0] center_x;
    logic [COORD_W-1:0] center_y;
    logic [COORD_W-1:0] wipe_steps;
    mode_t              mode_q;
    logic               running_q;
    logic [COORD_W-1:0] count_q;
    logic [COORD_W-1:0] radius_q;

    assign wipe_count   = count_q;

    task automatic report(input string what);
        $display("[%0t] status mismatch: %s", $time, what);
        errors++;
    endtask

    task automatic check_field(input string name, input int got, input int want);
        if (got != want)
            report($sformatf("%s got %0d expected %0d", name, got, want));
    endtask

    function automatic logic pixel_dark(input logic [COORD_W-1:0] px,
                                        input logic [COORD_W-1:0] py);
        int dx;
        int dy;
        int tx;
        int ty;
        int r;
        if (px >= SCREEN_WIDTH || py >= SCREEN_HEIGHT)
            return 1'b1;
        dx = (px >= center_x) ? int'(px - center_x) : int'(center_x - px);
        dy = (py >= center_y) ? int'(py - center_y) : int'(center_y - py);
        r  = int'(radius_q);
        if (dx > r || dy > r)
            return 1'b1;
        // snap the offsets down to whole cells
        tx = (dx / CELL_WIDTH) * CELL_WIDTH;
        ty = (dy / CELL_HEIGHT) * CELL_HEIGHT;
        return (tx * tx + ty * ty < r * r) ? 1'b0 : 1'b1;
    endfunction

    function automatic void advance_frame();
        if (mode_q == MODE_NONE)
            return;
        // a finished close wipe stays shut
        if (!running_q)
        begin
            radius_q = '0;
            return;
        end
        if (count_q == wipe_steps)
        begin
            running_q = 1'b0;
            if (mode_q == MODE_OPEN)
                mode_q = MODE_NONE;
        end
        else
        begin
            count_q = count_q + 1'b1;
        end
        if (mode_q == MODE_CLOSE)
            radius_q = (count_q >= wipe_steps) ? '0 : wipe_steps - count_q;
        else
            radius_q = count_q;
    endfunction

    function automatic mask_status_t next_status(input kind_t k, input mode_t m,
                                                 input logic [COORD_W-1:0] px,
                                                 input logic [COORD_W-1:0] py);
        mask_status_t s;
        logic         dark;
        dark = 1'b0;
        case (k)
            KIND_START:
            begin
                if (!running_q)
                begin
                    mode_q   = (m == MODE_BAD) ? MODE_NONE : m;
                    count_q  = '0;
                    radius_q = '0;
                end
                running_q = 1'b1;
            end
            KIND_TICK:  advance_frame();
            KIND_QUERY: dark = pixel_dark(px, py);
            default:    ;
        endcase
        s.shown  = (mode_q != MODE_NONE);
        s.black  = dark;
        s.active = running_q;
        s.radius = radius_q;
        return s;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch
        mask_status_t want;
        if (!rst_n)
        begin
            center_x   = '0;
            center_y   = '0;
            wipe_steps = WIPE_STEPS_RESET;
            mode_q     = MODE_NONE;
            running_q  = 1'b0;
            count_q    = '0;
            radius_q   = '0;
            errors     = 0;
            pending_status.delete();
        end
        else
        begin
            if (result.valid && result.ready)
            begin
                if (pending_status.size() == 0)
                begin
                    report("result beat with no status pending");
                end
                else
                begin
                    want = pending_status.pop_front();
                    check_field("mask_shown", result.mask_shown, want.shown);
                    check_field("pixel_black", result.pixel_black, want.black);
                    check_field("wipe_active", result.wipe_active, want.active);
                    check_field("radius", result.radius, want.radius);
                end
            end
            if (item.valid && item.ready)
                pending_status.push_back(next_status(kind_t'(item.kind),
                                                     mode_t'(item.start_mode),
                                                     item.pixel_x, item.pixel_y));
            if (cfg_write)
            begin
                case (reg_idx_t'(cfg_index))
                    REG_CENTER_X:   center_x = cfg_data;
                    REG_CENTER_Y:   center_y = cfg_data;
                    REG_WIPE_STEPS: wipe_steps = cfg_data;
                    default:        ;
                endcase
            end
        end
        pending = pending_status.size();
    end

endmodule

@@ tb/sv/tb.sv @@
`timescale 1ns / 1ps
// Testbench top for the iris wipe mask unit: clock, reset, stimulus and the
// verdict. Depends on iwm_pkg, iwm_if, iwm_mask_checker and the unit's RTL.

module tb;
    import iwm_pkg::*;

    localparam int COORD_MAX       = (1 << COORD_W) - 1;
    localparam int CYCLE_LIMIT     = 400000;
    localparam int HOLD_OFF_CYCLES = 80;
    localparam int DRAIN_CYCLES    = 16;
    localparam int IDLE_PCT        = 18;

    logic               clk = 1'b0;
    logic               rst_n;
    logic               cfg_write;
    logic [1:0]         cfg_index;
    logic [COORD_W-1:0] cfg_data;

    // checker side
    int                 mismatches;
    int                 in_flight;
    logic [COORD_W-1:0] status_count;

    // register values last written, used to aim pixel queries at the iris
    logic [COORD_W-1:0] cur_cx;
    logic [COORD_W-1:0] cur_cy;
    logic [COORD_W-1:0] cur_steps;

    int cycle_count;
    bit steady;        // no idling on either side while set
    bit hold_off_req;  // ask the result side for one long stall

    iwm_in_if  item_ch();
    iwm_out_if result_ch();

    iris_wipe_mask_unit u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .item      (item_ch),
        .result    (result_ch),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    iwm_mask_checker u_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .item         (item_ch),
        .result       (result_ch),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .errors       (mismatches),
        .pending      (in_flight),
        .wipe_count   (status_count)
    );

    always #5 clk = ~clk;

    // Watchdog: end the run if the stimulus or the drain never completes.
    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("timeout after %0d cycles, %0d beats still in flight",
                 cycle_count, in_flight);
        $display("simulation failed");
        $finish;
    end

    // Result side: drop ready at random, hold it high through the steady
    // stretch, and on request hold off for a long stall counted here, so the
    // unit fills up and pushes back on the item side.
    initial
    begin
        result_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_off_req)
            begin
                result_ch.ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge clk);
                hold_off_req = 1'b0;
            end
            result_ch.ready <= steady || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    // Pick a coordinate within span of c, clamped to the screen.
    function automatic logic [COORD_W-1:0] near_coord(input logic [COORD_W-1:0] c,
                                                      input int span);
        int v;
        v = int'(c) + int'($urandom_range(2 * span)) - span;
        if (v < 0)
            v = 0;
        if (v > COORD_MAX)
            v = COORD_MAX;
        return COORD_W'(v);
    endfunction

    // Offer one item beat. Called at a rising edge; returns at the edge where
    // the beat is taken, with valid still high so a following beat can go
    // out back to back. Random gaps drop valid first.
    task automatic send_beat(input kind_t k, input mode_t m,
                             input logic [COORD_W-1:0] x,
                             input logic [COORD_W-1:0] y);
        while (!steady && $urandom_range(99) < IDLE_PCT)
        begin
            item_ch.valid <= 1'b0;
            @(posedge clk);
        end
        item_ch.valid      <= 1'b1;
        item_ch.kind       <= k;
        item_ch.start_mode <= m;
        item_ch.pixel_x    <= x;
        item_ch.pixel_y    <= y;
        do
            @(posedge clk);
        while (!item_ch.ready);
    endtask

    // Drop valid and wait until every expected result has been taken.
    // Every item yields a result, so nothing is left inside once this ends.
    task automatic wait_idle();
        item_ch.valid <= 1'b0;
        do
            @(negedge clk);
        while (in_flight != 0);
        @(posedge clk);
    endtask

    task automatic write_reg(input reg_idx_t idx, input logic [COORD_W-1:0] value);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
    endtask

    // Rewrite all registers with the unit idle; the unused index gets junk
    // each time and must be ignored.
    task automatic write_config(input logic [COORD_W-1:0] cx,
                                input logic [COORD_W-1:0] cy,
                                input logic [COORD_W-1:0] steps);
        wait_idle();
        write_reg(REG_CENTER_X, cx);
        write_reg(REG_CENTER_Y, cy);
        write_reg(REG_WIPE_STEPS, steps);
        write_reg(REG_UNUSED, COORD_W'($urandom));
        cfg_write <= 1'b0;
        cur_cx    = cx;
        cur_cy    = cy;
        cur_steps = steps;
    endtask

    // One beat of background traffic: mostly queries around the iris, some
    // anywhere, some no-op beats, stray starts and stray ticks. Starts pick
    // open or close only, unless any_start allows the mask-off modes.
    task automatic send_filler(input bit any_start);
        int                 pick;
        int                 span;
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        span = int'(cur_steps) + 8;
        pick = $urandom_range(99);
        x    = near_coord(cur_cx, span);
        y    = near_coord(cur_cy, span);
        if (pick < 72)
            send_beat(KIND_QUERY, mode_t'($urandom_range(3)), x, y);
        else if (pick < 84)
            send_beat(KIND_QUERY, mode_t'($urandom_range(3)),
                      COORD_W'($urandom), COORD_W'($urandom));
        else if (pick < 90)
            send_beat(KIND_NOP, mode_t'($urandom_range(3)),
                      COORD_W'($urandom), COORD_W'($urandom));
        else if (pick < 96)
            send_beat(KIND_START,
                      any_start ? mode_t'($urandom_range(3))
                                : ($urandom_range(1) ? MODE_OPEN : MODE_CLOSE),
                      x, y);
        else
            send_beat(KIND_TICK, mode_t'($urandom_range(3)), x, y);
    endtask

    // A phase: new register values, then wipes back to back. Each wipe is a
    // start followed by a run of frame ticks, sometimes short of the finish
    // and sometimes past it, with queries and noise between the ticks.
    task automatic run_phase(input logic [COORD_W-1:0] cx,
                             input logic [COORD_W-1:0] cy,
                             input logic [COORD_W-1:0] steps,
                             input mode_t lead, input int budget, input bit squeeze);
        int sent;
        int ticks;
        int k;
        int extra;
        write_config(cx, cy, steps);
        sent = 0;
        while (sent < budget)
        begin
            send_beat(KIND_START,
                      (sent == 0) ? lead : ($urandom_range(1) ? MODE_OPEN : MODE_CLOSE),
                      COORD_W'($urandom), COORD_W'($urandom));
            // start the long result stall while items keep coming
            if (squeeze && sent == 0)
                hold_off_req = 1'b1;
            sent++;
            ticks = (steps <= 40) ? int'($urandom_range(int'(steps) + 3))
                                  : int'($urandom_range(40, 5));
            for (k = 0; k <= ticks && sent < budget; k++)
            begin
                extra = int'($urandom_range(4));
                repeat (extra)
                begin
                    send_filler(1'b0);
                    sent++;
                end
                if (k < ticks)
                begin
                    send_beat(KIND_TICK, mode_t'($urandom_range(3)),
                              COORD_W'($urandom), COORD_W'($urandom));
                    sent++;
                end
            end
        end
    endtask

    initial
    begin
        rst_n              <= 1'b0;
        item_ch.valid      <= 1'b0;
        item_ch.kind       <= KIND_NOP;
        item_ch.start_mode <= MODE_NONE;
        item_ch.pixel_x    <= '0;
        item_ch.pixel_y    <= '0;
        cfg_write          <= 1'b0;
        cfg_index          <= REG_CENTER_X;
        cfg_data           <= '0;
        steady       = 1'b0;
        hold_off_req = 1'b0;
        cur_cx       = '0;
        cur_cy       = '0;
        cur_steps    = WIPE_STEPS_RESET;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part, first on the reset register values (center at the
        // corner, 32 steps). With the mask off and radius 0 every pixel is
        // black, no-op beats and ticks change nothing.
        send_beat(KIND_QUERY, MODE_NONE, 0, 0);
        send_beat(KIND_NOP, MODE_BAD, COORD_MAX, COORD_MAX);
        send_beat(KIND_TICK, MODE_BAD, 0, COORD_MAX);
        // Close wipe: all black at the start, radius 31 after one tick.
        send_beat(KIND_START, MODE_CLOSE, COORD_MAX, 0);
        send_beat(KIND_TICK, MODE_NONE, 0, 0);
        // center, far corner, box edge snapped to a cell, corner of the box
        send_beat(KIND_QUERY, MODE_NONE, 0, 0);
        send_beat(KIND_QUERY, MODE_NONE, COORD_MAX, COORD_MAX);
        send_beat(KIND_QUERY, MODE_NONE, 31, 0);
        send_beat(KIND_QUERY, MODE_NONE, 31, 31);
        // starts of every mode are dropped while the wipe runs
        send_beat(KIND_START, MODE_OPEN, 0, 0);
        send_beat(KIND_START, MODE_NONE, 0, 0);
        send_beat(KIND_START, MODE_BAD, 0, 0);

        // Center in the far corner and two steps: finish the close wipe,
        // tick once more after it, then run a short open wipe to the end
        // where the mask switches off; the pixel test still uses the radius.
        write_config(COORD_MAX, COORD_MAX, 2);
        send_beat(KIND_TICK, MODE_OPEN, 0, 0);
        send_beat(KIND_TICK, MODE_OPEN, 0, 0);
        send_beat(KIND_TICK, MODE_OPEN, 0, 0);
        send_beat(KIND_QUERY, MODE_NONE, COORD_MAX, COORD_MAX);
        send_beat(KIND_START, MODE_OPEN, 0, 0);
        send_beat(KIND_TICK, MODE_NONE, 0, 0);
        send_beat(KIND_QUERY, MODE_NONE, COORD_MAX, COORD_MAX - 1);
        send_beat(KIND_TICK, MODE_NONE, 0, 0);
        send_beat(KIND_TICK, MODE_NONE, 0, 0);
        send_beat(KIND_QUERY, MODE_NONE, COORD_MAX - 3, COORD_MAX - 2);
        send_beat(KIND_QUERY, MODE_NONE, COORD_MAX - 1, COORD_MAX);
        send_beat(KIND_TICK, MODE_CLOSE, 0, 0);

        // Random part. First a stretch with no idling on either side.
        steady = 1'b1;
        run_phase(512, 384, 20, MODE_OPEN, 130, 1'b0);
        steady = 1'b0;
        // center in one corner, then the other, with the shortest wipes
        run_phase(0, 0, 1, MODE_CLOSE, 110, 1'b0);
        run_phase(COORD_MAX, COORD_MAX, 0, MODE_OPEN, 90, 1'b0);
        // Longest wipe: a close wipe sweeps huge radii and will not finish
        // here. Stall the result side for a long while in this phase.
        run_phase(COORD_W'($urandom), COORD_W'($urandom), COORD_MAX,
                  MODE_CLOSE, 120, 1'b1);
        // Lower the step limit under the running count: the count keeps
        // rising, the close radius stays at 0 and starts are dropped.
        wait_idle();
        run_phase(COORD_W'($urandom), COORD_W'($urandom), status_count / 2,
                  MODE_CLOSE, 100, 1'b0);
        // Raise the limit just above the count so the stuck wipe can end.
        wait_idle();
        run_phase(COORD_W'($urandom), COORD_W'($urandom),
                  COORD_W'((status_count > COORD_MAX - 20) ? COORD_MAX
                           : int'(status_count) + int'($urandom_range(20, 3))),
                  MODE_OPEN, 120, 1'b0);
        run_phase(COORD_W'($urandom), COORD_W'($urandom), COORD_W'($urandom_range(40, 2)),
                  MODE_CLOSE, 130, 1'b0);

        // Last: finish whatever wipe runs (limit equals the count, one tick),
        // then start with the mask off. That leaves the unit running with no
        // mask for good, so it comes only now; follow with noise of all kinds.
        wait_idle();
        write_config(COORD_W'($urandom), COORD_W'($urandom), status_count);
        send_beat(KIND_TICK, MODE_NONE, 0, 0);
        send_beat(KIND_START, $urandom_range(1) ? MODE_NONE : MODE_BAD,
                  COORD_W'($urandom), COORD_W'($urandom));
        repeat (14) send_filler(1'b1);

        // Drain, then give any stray beat time to show up.
        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
